// ----- hw/rtl/tkch_pkg.sv -----
// Package for the tuple-keyed chained hash table.
// Sizes, status and register codes shared by the table and hash modules; no dependencies.
package tkch_pkg;
    localparam int BUCKETS = 1024;
    localparam int NODES   = 1024;
    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int NEXT_W = NW + 1;
    localparam int HEAD_W = NW + 1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;
    localparam logic [2:0] REG_RADIX = 3'd0;
    localparam logic [7:0] RADIX_RESET = 8'd10;

    // handshake between sequencer and hash unit
    typedef struct packed {
        logic start;
    } hash_ctl_t;
    typedef struct packed {
        logic          done;
        logic [BW-1:0] bucket;
    } hash_sts_t;
endpackage

// ----- hw/rtl/tuple_key_chained_hash_table.sv -----
// Tuple-keyed chained hash table. After reset the block clears all BUCKETS
// (1024) bucket head entries and accepts no request meanwhile.
// One request is in flight at a time. Each passes the hash and the bucket
// head read (S_HRD, S_HWAIT) to a decision; an insert that appends to a
// chain then clears the new node's next entry, and a lookup reads and
// compares each chain node visited (S_NWAIT, S_NCMP). The hash uses one
// shared multiply-add over the four key elements, and the chain walk is
// bound by the registered read of the node memories.
module tuple_key_chained_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: key_len[2:0], key_a[18:3], key_b[34:19], key_c[50:35],
    //        key_d[66:51], value_in[98:67], zero fill to 104
    input  logic [103:0] s_tdata,
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[1:0], value_out[33:2], zero fill to 40
    output logic [39:0] m_tdata
);
    localparam int BW = tkch_pkg::BW;
    localparam int NW = tkch_pkg::NW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HRD, S_HWAIT, S_HDEC,
        S_NRD, S_NWAIT, S_NCMP, S_OUT
    } state_t;

    state_t state_reg;
    logic [7:0]  radix_reg;
    logic [BW-1:0] clr_reg;
    logic        mode_reg;
    logic [63:0] key_reg;
    logic [31:0] val_reg;
    logic [BW-1:0] bkt_reg;
    logic [NW-1:0] cur_reg;
    logic [NW:0]   used_reg;
    logic [1:0]  st_reg;
    logic [31:0] vout_reg;
    logic        oval_reg;

    tkch_pkg::hash_ctl_t hctl;
    tkch_pkg::hash_sts_t hsts;

    logic wr_cfg;
    assign wr_cfg = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == {tkch_pkg::REG_RADIX[0], 2'b00}) ?
                    {24'd0, radix_reg} : 32'd0;

    // key padding
    logic [2:0]  klen;
    logic [63:0] kin;
    always_comb begin
        klen = s_tdata[2:0];
        kin  = s_tdata[66:3];
        if (klen < 3'd4) kin[63:48] = '0;
        if (klen < 3'd3) kin[47:32] = '0;
        if (klen < 3'd2) kin[31:16] = '0;
        if (klen < 3'd1) kin[15:0]  = '0;
    end

    logic s_acc;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign hctl.start = s_acc;

    tkch_hash u_hash (
        .aclk(aclk), .aresetn(aresetn), .ctl(hctl), .radix(radix_reg),
        .key(key_reg), .sts(hsts)
    );

    // memories
    logic              head_we, tail_we, node_we, next_we;
    logic [BW-1:0]     head_wa;
    logic [NW:0]       head_wd, head_rd;
    logic [NW-1:0]     tail_rd;
    logic [NW-1:0]     next_wa;
    logic [NW:0]       next_wd, next_rd;
    logic [63:0]       key_rd;
    logic [31:0]       val_rd;
    logic              full;

    assign full = (used_reg == (NW+1)'(tkch_pkg::NODES));

    tkch_ram #(.WIDTH(NW+1), .DEPTH(tkch_pkg::BUCKETS)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
        .raddr(bkt_reg), .rdata(head_rd));
    tkch_ram #(.WIDTH(NW), .DEPTH(tkch_pkg::BUCKETS)) u_tail (
        .aclk(aclk), .we(tail_we), .waddr(bkt_reg), .wdata(used_reg[NW-1:0]),
        .raddr(bkt_reg), .rdata(tail_rd));
    tkch_ram #(.WIDTH(64), .DEPTH(tkch_pkg::NODES)) u_keys (
        .aclk(aclk), .we(node_we), .waddr(used_reg[NW-1:0]), .wdata(key_reg),
        .raddr(cur_reg), .rdata(key_rd));
    tkch_ram #(.WIDTH(32), .DEPTH(tkch_pkg::NODES)) u_vals (
        .aclk(aclk), .we(node_we), .waddr(used_reg[NW-1:0]), .wdata(val_reg),
        .raddr(cur_reg), .rdata(val_rd));
    tkch_ram #(.WIDTH(NW+1), .DEPTH(tkch_pkg::NODES)) u_next (
        .aclk(aclk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(cur_reg), .rdata(next_rd));

    logic nclr_reg;   // new node's next entry still pending clear
    // the S_NRD cycle writes the cleared next entry of the new node
    logic nclr_we;
    assign nclr_we = (state_reg == S_NRD) && nclr_reg;

    logic ins_go;
    assign ins_go = (state_reg == S_HDEC) && (mode_reg == tkch_pkg::MODE_INSERT)
                    && !full;
    always_comb begin
        head_we = 1'b0; head_wa = bkt_reg; head_wd = {1'b1, used_reg[NW-1:0]};
        tail_we = 1'b0; node_we = 1'b0; next_we = 1'b0;
        next_wa = used_reg[NW-1:0]; next_wd = '0;
        if (state_reg == S_CLEAR) begin
            head_we = 1'b1; head_wa = clr_reg; head_wd = '0;
        end else if (ins_go) begin
            node_we = 1'b1; tail_we = 1'b1;
            if (head_rd[NW]) begin
                // link old tail to the new node; its own next entry follows
                next_we = 1'b1; next_wa = tail_rd;
                next_wd = {1'b1, used_reg[NW-1:0]};
            end else begin
                head_we = 1'b1; next_we = 1'b1;
            end
        end else if (nclr_we) begin
            next_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            radix_reg <= tkch_pkg::RADIX_RESET;
            used_reg  <= '0;
            oval_reg  <= 1'b0;
        end else begin
            if (wr_cfg && paddr == {tkch_pkg::REG_RADIX[0], 2'b00}) begin
                radix_reg <= pwdata[7:0];
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(tkch_pkg::BUCKETS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_acc) begin
                        mode_reg <= s_tuser;
                        key_reg  <= kin;
                        val_reg  <= s_tdata[98:67];
                        state_reg <= S_HASH;
                    end
                end
                S_HASH: if (hsts.done) begin
                    bkt_reg <= hsts.bucket; state_reg <= S_HRD;
                end
                S_HRD:   state_reg <= S_HWAIT;
                S_HWAIT: state_reg <= S_HDEC;
                S_HDEC: begin
                    vout_reg <= '0;
                    if (mode_reg == tkch_pkg::MODE_INSERT) begin
                        if (full) begin
                            st_reg <= tkch_pkg::ST_FULL; state_reg <= S_OUT;
                            oval_reg <= 1'b1;
                        end else if (head_rd[NW]) begin
                            nclr_reg <= 1'b1; state_reg <= S_NRD;
                        end else begin
                            used_reg <= used_reg + (NW+1)'(1);
                            st_reg <= tkch_pkg::ST_INSERTED; state_reg <= S_OUT;
                            oval_reg <= 1'b1;
                        end
                    end else if (head_rd[NW]) begin
                        cur_reg <= head_rd[NW-1:0]; state_reg <= S_NWAIT;
                    end else begin
                        st_reg <= tkch_pkg::ST_NOT_FOUND; state_reg <= S_OUT;
                        oval_reg <= 1'b1;
                    end
                end
                S_NRD: begin
                    // clear new node's next pointer (tail link written last cycle)
                    nclr_reg <= 1'b0;
                    used_reg <= used_reg + (NW+1)'(1);
                    st_reg <= tkch_pkg::ST_INSERTED; state_reg <= S_OUT;
                    oval_reg <= 1'b1;
                end
                S_NWAIT: state_reg <= S_NCMP;
                S_NCMP: begin
                    if (key_rd == key_reg) begin
                        st_reg <= tkch_pkg::ST_FOUND; vout_reg <= val_rd;
                        state_reg <= S_OUT; oval_reg <= 1'b1;
                    end else if (next_rd[NW]) begin
                        cur_reg <= next_rd[NW-1:0]; state_reg <= S_NWAIT;
                    end else begin
                        st_reg <= tkch_pkg::ST_NOT_FOUND; state_reg <= S_OUT;
                        oval_reg <= 1'b1;
                    end
                end
                S_OUT: if (m_tready) begin
                    oval_reg <= 1'b0; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = {6'd0, vout_reg, st_reg};

    always_ff @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            assert (state_reg == S_OUT) else $error("result outside output state");
        end
    end
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during output");
    a_used: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= (NW+1)'(tkch_pkg::NODES)) else $error("pool count overflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && st_reg == tkch_pkg::ST_FULL) |-> full)
        else $error("full reported with free nodes");
endmodule

// ----- hw/rtl/tkch_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tkch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/tkch_hash.sv -----
// Iterative polynomial hash: one shared multiply-add per cycle (Horner form).
// Depends on tkch_pkg.
module tkch_hash (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tkch_pkg::hash_ctl_t    ctl,
    input  logic [7:0]             radix,
    input  logic [63:0]            key,
    output tkch_pkg::hash_sts_t    sts
);
    // Sum k_i*r^(4-i) = r*(r*(r*(r*k0 + k1) + k2) + k3). Only the low bits
    // matter since the bucket count is a power of two.
    logic [2:0]             cnt_reg, cnt_next;
    logic [tkch_pkg::BW-1:0] acc_reg, acc_next;
    logic                   busy_reg, busy_next;
    logic [15:0]            elem;
    logic [tkch_pkg::BW+15:0] prod;

    always_comb begin
        elem = key[16*cnt_reg[1:0] +: 16];
        prod = ({{16{1'b0}}, acc_reg} + {{tkch_pkg::BW{elem[15]}}, elem})
               * {{(tkch_pkg::BW+8){1'b0}}, radix};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = prod[tkch_pkg::BW-1:0];
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd3) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
    end

    assign sts.done   = busy_reg && !busy_next;
    assign sts.bucket = acc_next;
endmodule
